// ----- design/disjoint_set_union_engine_assert.svh -----
// ----------------------------------------------------------------------------
// disjoint-set union engine assertion macros
// shared property forms for the engine's concurrent checks
// ----------------------------------------------------------------------------
`ifndef DISJOINT_SET_UNION_ENGINE_ASSERT_SVH
`define DISJOINT_SET_UNION_ENGINE_ASSERT_SVH

// same-cycle implication, masked during reset
`define DSU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define DSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/dsu_pkg.sv -----
// ----------------------------------------------------------------------------
// dsu_pkg
// shared constants, word types and controller/datapath interface structs
// ----------------------------------------------------------------------------
`default_nettype none

package dsu_pkg;

   // element index width and table depth
   localparam int ELEM_W       = 10;
   localparam int MAX_ELEMENTS = 1 << ELEM_W;
   localparam int COUNT_W      = ELEM_W + 1;
   localparam int RANK_W       = 4;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_ELEMENTS);
   localparam logic [RANK_W-1:0]  RANK_MAX    = '1;

   // command codes
   typedef enum logic [1:0] {
      CMD_FIND  = 2'd0,
      CMD_UNION = 2'd1,
      CMD_MAKE  = 2'd2,
      CMD_NONE  = 2'd3
   } dsu_cmd_type;

   // request word
   typedef struct packed {
      dsu_cmd_type       command;
      logic [ELEM_W-1:0] elem_a;
      logic [ELEM_W-1:0] elem_b;
   } dsu_req_type;

   // response word
   typedef struct packed {
      logic [ELEM_W-1:0] root;
      logic              merged;
      logic              same_set;
      logic              bad_index;
   } dsu_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic self_link;
      logic load_start;
      logic walk_next;
      logic root_take;
      logic comp_start;
      logic comp_step;
      logic rank_b_rd;
      logic link;
      logic rsp_load;
      logic phase_b;
   } dsu_ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic        clear_last;
      logic        bad;
      dsu_cmd_type cmd;
      logic        at_root;
      logic        start_is_cur;
      logic        comp_done;
      logic        roots_equal;
      logic        out_free;
   } dsu_sts_type;

endpackage

`default_nettype wire

// ----- design/disjoint_set_union_engine.sv -----
// ----------------------------------------------------------------------------
// disjoint_set_union_engine
// union-find table with path compression and union by rank
// ----------------------------------------------------------------------------
// Request channel (req_valid, req_stall, req_word) carries a command with one
// or two element indices; each request word gives exactly one response word
// on the response channel (rsp_valid, rsp_stall, rsp_word). The csr write
// channel (csr_valid, csr_ready, csr_wdata) sets the element count; it is
// always ready and should only be written while the engine is idle.
// One request is processed at a time. A find loads its start element, follows
// parent links to the root and then points each element on the path at the
// root; a union does this for both elements and, when the roots differ, reads
// both ranks and links them. A rejected index, make-set or unused command is
// answered without a walk. The next request can be taken in the cycle after
// the response is loaded. The parent memory has a single read port, which is
// read once per link on the walk and again on the compression pass.
// After reset the engine clears all 1024 entries of the parent and rank
// memories, one entry per cycle, with req_stall high; csr writes are taken.
// A finished response waits in the output register while rsp_stall is high;
// the next request is accepted meanwhile and held at its end until the
// register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module disjoint_set_union_engine (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire dsu_pkg::dsu_req_type        req_word,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      dsu_pkg::dsu_rsp_type        rsp_word,
   input  wire logic                        csr_valid,
   output      logic                        csr_ready,
   input  wire logic [dsu_pkg::COUNT_W-1:0] csr_wdata
);

   dsu_pkg::dsu_ctl_type ctl;
   dsu_pkg::dsu_sts_type sts;

   // sequencer
   dsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // memories and working registers
   dsu_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

endmodule

`default_nettype wire

// ----- design/dsu_ram.sv -----
// ----------------------------------------------------------------------------
// dsu_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module dsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- design/dsu_datapath.sv -----
// ----------------------------------------------------------------------------
// dsu_datapath
// parent and rank memories, walk registers, set count and response register
// ----------------------------------------------------------------------------
`default_nettype none
`include "disjoint_set_union_engine_assert.svh"

module dsu_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dsu_pkg::dsu_ctl_type          ctl,
   output      dsu_pkg::dsu_sts_type          sts,
   input  wire dsu_pkg::dsu_req_type          req_word,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      dsu_pkg::dsu_rsp_type          rsp_word,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [dsu_pkg::COUNT_W-1:0]   csr_wdata
);

   logic [dsu_pkg::ELEM_W-1:0]  clr_ff, clr_in;
   logic [dsu_pkg::ELEM_W-1:0]  a_ff, a_in;
   logic [dsu_pkg::ELEM_W-1:0]  b_ff, b_in;
   logic [dsu_pkg::ELEM_W-1:0]  cur_ff, cur_in;
   logic [dsu_pkg::ELEM_W-1:0]  root_a_ff, root_a_in;
   logic [dsu_pkg::ELEM_W-1:0]  root_b_ff, root_b_in;
   logic [dsu_pkg::ELEM_W-1:0]  link_root_ff, link_root_in;
   dsu_pkg::dsu_cmd_type        cmd_ff, cmd_in;
   logic                        bad_ff, bad_in;
   logic [dsu_pkg::RANK_W-1:0]  rank_a_ff, rank_a_in;
   logic [dsu_pkg::COUNT_W-1:0] set_count_ff, set_count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   dsu_pkg::dsu_rsp_type        rsp_word_ff, rsp_word_in;

   logic                        p_we;
   logic [dsu_pkg::ELEM_W-1:0]  p_waddr, p_wdata, p_raddr, p_rdata;
   logic                        r_we;
   logic [dsu_pkg::ELEM_W-1:0]  r_waddr, r_raddr;
   logic [dsu_pkg::RANK_W-1:0]  r_wdata, r_rdata;

   logic [dsu_pkg::ELEM_W-1:0]  start_elem, root_sel;
   logic [dsu_pkg::ELEM_W-1:0]  link_child, link_parent;
   logic                        a_low, a_high, bump;
   logic                        req_bad, out_free;
   dsu_pkg::dsu_rsp_type        result;

   // current walk origin and target root
   assign start_elem = ctl.phase_b ? b_ff : a_ff;
   assign root_sel   = ctl.phase_b ? root_b_ff : root_a_ff;

   // index check on the incoming word
   assign req_bad = (req_word.command != dsu_pkg::CMD_NONE) &&
                    ((dsu_pkg::COUNT_W'(req_word.elem_a) >= set_count_ff) ||
                     ((req_word.command == dsu_pkg::CMD_UNION) &&
                      (dsu_pkg::COUNT_W'(req_word.elem_b) >= set_count_ff)));

   // union by rank, rank of second root is on the rank read port
   assign a_low       = rank_a_ff < r_rdata;
   assign a_high      = rank_a_ff > r_rdata;
   assign link_child  = a_low ? root_a_ff : root_b_ff;
   assign link_parent = a_low ? root_b_ff : root_a_ff;
   assign bump        = !a_low && !a_high && (rank_a_ff != dsu_pkg::RANK_MAX);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // parent memory ports
   always_comb begin
      p_we    = 1'b0;
      p_waddr = cur_ff;
      p_wdata = root_sel;
      if (ctl.clear_step) begin
         p_we    = 1'b1;
         p_waddr = clr_ff;
         p_wdata = clr_ff;
      end else if (ctl.self_link) begin
         p_we    = 1'b1;
         p_waddr = a_ff;
         p_wdata = a_ff;
      end else if (ctl.comp_step) begin
         p_we    = 1'b1;
      end else if (ctl.link) begin
         p_we    = 1'b1;
         p_waddr = link_child;
         p_wdata = link_parent;
      end
      p_raddr = start_elem;
      if (ctl.walk_next || ctl.comp_step) begin
         p_raddr = p_rdata;
      end
   end

   // rank memory ports
   always_comb begin
      r_we    = 1'b0;
      r_waddr = root_a_ff;
      r_wdata = rank_a_ff + dsu_pkg::RANK_W'(1);
      if (ctl.clear_step) begin
         r_we    = 1'b1;
         r_waddr = clr_ff;
         r_wdata = '0;
      end else if (ctl.link && bump) begin
         r_we    = 1'b1;
      end
      r_raddr = ctl.rank_b_rd ? root_b_ff : root_a_ff;
   end

   dsu_ram #(
      .WIDTH (dsu_pkg::ELEM_W),
      .DEPTH (dsu_pkg::MAX_ELEMENTS)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   dsu_ram #(
      .WIDTH (dsu_pkg::RANK_W),
      .DEPTH (dsu_pkg::MAX_ELEMENTS)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (r_we),
      .wr_addr (r_waddr),
      .wr_data (r_wdata),
      .rd_addr (r_raddr),
      .rd_data (r_rdata)
   );

   // response contents
   always_comb begin
      result = '0;
      if (bad_ff) begin
         result.bad_index = 1'b1;
      end else begin
         case (cmd_ff)
            dsu_pkg::CMD_FIND: begin
               result.root = root_a_ff;
            end
            dsu_pkg::CMD_MAKE: begin
               result.root = a_ff;
            end
            dsu_pkg::CMD_UNION: begin
               if (root_a_ff == root_b_ff) begin
                  result.same_set = 1'b1;
                  result.root     = root_a_ff;
               end else begin
                  result.merged   = 1'b1;
                  result.root     = link_root_ff;
               end
            end
            default: begin
               result = '0;
            end
         endcase
      end
   end

   // next values
   always_comb begin
      clr_in       = ctl.clear_step ? clr_ff + dsu_pkg::ELEM_W'(1) : clr_ff;
      a_in         = ctl.capture ? req_word.elem_a : a_ff;
      b_in         = ctl.capture ? req_word.elem_b : b_ff;
      cmd_in       = ctl.capture ? req_word.command : cmd_ff;
      bad_in       = ctl.capture ? req_bad : bad_ff;
      set_count_in = csr_valid ? csr_wdata : set_count_ff;
      rank_a_in    = ctl.rank_b_rd ? r_rdata : rank_a_ff;
      link_root_in = ctl.link ? link_parent : link_root_ff;

      cur_in = cur_ff;
      if (ctl.load_start || ctl.comp_start) begin
         cur_in = start_elem;
      end else if (ctl.walk_next || ctl.comp_step) begin
         cur_in = p_rdata;
      end

      root_a_in = root_a_ff;
      root_b_in = root_b_ff;
      if (ctl.root_take) begin
         if (ctl.phase_b) begin
            root_b_in = cur_ff;
         end else begin
            root_a_in = cur_ff;
         end
      end

      rsp_word_in  = ctl.rsp_load ? result : rsp_word_ff;
      rsp_valid_in = ctl.rsp_load | (rsp_valid_ff & rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         set_count_ff <= dsu_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         set_count_ff <= set_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      cmd_ff       <= cmd_in;
      bad_ff       <= bad_in;
      cur_ff       <= cur_in;
      root_a_ff    <= root_a_in;
      root_b_ff    <= root_b_in;
      rank_a_ff    <= rank_a_in;
      link_root_ff <= link_root_in;
      rsp_word_ff  <= rsp_word_in;
   end

   // status to controller
   always_comb begin
      sts              = '0;
      sts.clear_last   = (clr_ff == dsu_pkg::ELEM_W'(dsu_pkg::MAX_ELEMENTS - 1));
      sts.bad          = bad_ff;
      sts.cmd          = cmd_ff;
      sts.at_root      = (p_rdata == cur_ff);
      sts.start_is_cur = (start_elem == cur_ff);
      sts.comp_done    = (p_rdata == root_sel);
      sts.roots_equal  = (root_a_ff == root_b_ff);
      sts.out_free     = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign csr_ready = 1'b1;

   // compression never rewrites the root itself
   `DSU_ASSERT_IMPLY(a_comp_not_root, clock, reset, ctl.comp_step, cur_ff != root_sel, "compression wrote the root entry")
   // a new response never replaces one still waiting
   `DSU_ASSERT_IMPLY(a_rsp_no_overwrite, clock, reset, ctl.rsp_load, !rsp_valid_ff || !rsp_stall, "response register overwritten while stalled")

endmodule

`default_nettype wire

// ----- design/dsu_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsu_ctrl
// sequencer for clearing, root walks, path compression and linking
// ----------------------------------------------------------------------------
`default_nettype none
`include "disjoint_set_union_engine_assert.svh"

module dsu_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire dsu_pkg::dsu_sts_type sts,
   output      dsu_pkg::dsu_ctl_type ctl
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_LOAD,
      ST_WALK,
      ST_COMP,
      ST_PHASE,
      ST_RANK_A,
      ST_RANK_B,
      ST_LINK,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      phase_b_ff, phase_b_in;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      phase_b_in  = phase_b_ff;
      ctl         = '0;
      ctl.phase_b = phase_b_ff;
      case (state_ff)
         ST_CLEAR: begin
            ctl.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            phase_b_in = 1'b0;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            if (sts.bad || (sts.cmd == dsu_pkg::CMD_NONE)) begin
               state_in = ST_FINISH;
            end else if (sts.cmd == dsu_pkg::CMD_MAKE) begin
               ctl.self_link = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctl.load_start = 1'b1;
            state_in       = ST_WALK;
         end
         // follow parent links until an element points at itself
         ST_WALK: begin
            if (!sts.at_root) begin
               ctl.walk_next = 1'b1;
            end else begin
               ctl.root_take = 1'b1;
               if (sts.start_is_cur) begin
                  state_in = ST_PHASE;
               end else begin
                  ctl.comp_start = 1'b1;
                  state_in       = ST_COMP;
               end
            end
         end
         // second pass points each element on the path at the root
         ST_COMP: begin
            ctl.comp_step = 1'b1;
            if (sts.comp_done) begin
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: begin
            if ((sts.cmd == dsu_pkg::CMD_UNION) && !phase_b_ff) begin
               phase_b_in = 1'b1;
               state_in   = ST_LOAD;
            end else if ((sts.cmd == dsu_pkg::CMD_UNION) && !sts.roots_equal) begin
               state_in = ST_RANK_A;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_RANK_A: begin
            state_in = ST_RANK_B;
         end
         ST_RANK_B: begin
            ctl.rank_b_rd = 1'b1;
            state_in      = ST_LINK;
         end
         ST_LINK: begin
            ctl.link = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         phase_b_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_b_ff <= phase_b_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // rejected or unused commands go straight to the response
   `DSU_ASSERT_NEXT(a_start_bad, clock, reset, (state_ff == ST_START) && sts.bad, state_ff == ST_FINISH, "rejected word touched the table")
   // linking only ever joins two distinct roots
   `DSU_ASSERT_IMPLY(a_link_distinct, clock, reset, state_ff == ST_LINK, !sts.roots_equal, "link with equal roots")

endmodule

`default_nettype wire
